// ===== rtl/core/icc_pkg.sv =====
// Shared types and constants for the interval clock with compare.
package icc_pkg;

    // Bus action carried by each input word.
    typedef enum logic [1:0] {
        ACT_TICK   = 2'd0,
        ACT_HOLD   = 2'd1,
        ACT_DIRECT = 2'd2,
        ACT_READ   = 2'd3
    } t_action;

    localparam int unsigned DATA_W = 16;

    // Bit positions in the director function word.
    localparam int unsigned DIR_CLEAR_BIT   = 0;
    localparam int unsigned DIR_ACK_BIT     = 1;
    localparam int unsigned DIR_STOP_BIT    = 6;
    localparam int unsigned DIR_START_BIT   = 7;
    localparam int unsigned DIR_DISABLE_BIT = 14;
    localparam int unsigned DIR_ENABLE_BIT  = 15;

    // Status codes of a result word.
    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_REJECTED = 1'b1;

    // Command handed from the input register to the clock core.
    typedef struct packed {
        logic                valid;
        t_action             action;
        logic [DATA_W-1:0]   data;
    } t_cmd;

    // Result produced by the clock core for one command.
    typedef struct packed {
        logic [DATA_W-1:0]   read_data;
        logic                status;
        logic                interrupt_pending;
    } t_res;

endpackage

// ===== rtl/core/icc_if.sv =====
// Valid/ready channel interfaces for the input and result words.
interface icc_in_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    action;
    logic [icc_pkg::DATA_W-1:0]    data;

    modport source (output valid, output action, output data, input ready);
    modport sink   (input valid, input action, input data, output ready);
endinterface

interface icc_out_if;
    logic                          valid;
    logic                          ready;
    logic [icc_pkg::DATA_W-1:0]    read_data;
    logic                          status;
    logic                          interrupt_pending;

    modport source (output valid, output read_data, output status,
                    output interrupt_pending, input ready);
    modport sink   (input valid, input read_data, input status,
                    input interrupt_pending, output ready);
endinterface

// ===== rtl/core/icc_core.sv =====
// Clock state registers and the single-pass update for one command.
module icc_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  icc_pkg::t_cmd i_cmd,
    output icc_pkg::t_res o_res
);

    logic [icc_pkg::DATA_W-1:0] r_count, n_count;
    logic [icc_pkg::DATA_W-1:0] r_hold, n_hold;
    logic                       r_running, n_running;
    logic                       r_irq_en, n_irq_en;
    logic                       r_irq_latched, n_irq_latched;
    logic [icc_pkg::DATA_W-1:0] w_inc;
    logic [icc_pkg::DATA_W-1:0] w_word;
    logic                       w_illegal;

    assign w_inc  = r_count + {{(icc_pkg::DATA_W-1){1'b0}}, 1'b1};
    assign w_word = i_cmd.data;

    // A word asking for both enable and disable, or both start and stop, is refused.
    assign w_illegal = (w_word[icc_pkg::DIR_ENABLE_BIT] && w_word[icc_pkg::DIR_DISABLE_BIT]) ||
                       (w_word[icc_pkg::DIR_START_BIT] && w_word[icc_pkg::DIR_STOP_BIT]);

    // Next state and result for the command at the core input.
    always_comb begin
        n_count       = r_count;
        n_hold        = r_hold;
        n_running     = r_running;
        n_irq_en      = r_irq_en;
        n_irq_latched = r_irq_latched;
        o_res.read_data = '0;
        o_res.status    = icc_pkg::STATUS_OK;
        unique case (i_cmd.action)
            icc_pkg::ACT_TICK: begin
                if (r_running) begin
                    if (r_irq_en && (w_inc == r_hold)) begin
                        n_count       = '0;
                        n_irq_latched = 1'b1;
                    end else begin
                        n_count = w_inc;
                    end
                end
            end
            icc_pkg::ACT_HOLD: begin
                n_hold = i_cmd.data;
            end
            icc_pkg::ACT_DIRECT: begin
                if (w_illegal) begin
                    o_res.status = icc_pkg::STATUS_REJECTED;
                end else begin
                    // Functions apply in order: clear, stop, start, ack, disable, enable.
                    if (w_word[icc_pkg::DIR_CLEAR_BIT]) begin
                        n_running     = 1'b0;
                        n_irq_en      = 1'b0;
                        n_irq_latched = 1'b0;
                        n_hold        = '0;
                        n_count       = '0;
                    end
                    if (w_word[icc_pkg::DIR_STOP_BIT]) begin
                        n_running = 1'b0;
                    end
                    if (w_word[icc_pkg::DIR_START_BIT]) begin
                        n_count   = '0;
                        n_running = 1'b1;
                    end
                    if (w_word[icc_pkg::DIR_ACK_BIT]) begin
                        n_irq_latched = 1'b0;
                    end
                    if (w_word[icc_pkg::DIR_DISABLE_BIT]) begin
                        n_irq_en      = 1'b0;
                        n_irq_latched = 1'b0;
                    end
                    if (w_word[icc_pkg::DIR_ENABLE_BIT]) begin
                        n_irq_en = 1'b1;
                    end
                end
            end
            icc_pkg::ACT_READ: begin
                o_res.read_data = r_count;
            end
            default: begin
                o_res.read_data = '0;
            end
        endcase
        o_res.interrupt_pending = n_irq_latched;
    end

    // State registers advance only when a command is consumed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count       <= '0;
            r_hold        <= '0;
            r_running     <= 1'b0;
            r_irq_en      <= 1'b0;
            r_irq_latched <= 1'b0;
        end else if (i_cmd.valid) begin
            r_count       <= n_count;
            r_hold        <= n_hold;
            r_running     <= n_running;
            r_irq_en      <= n_irq_en;
            r_irq_latched <= n_irq_latched;
        end
    end

endmodule

// ===== rtl/core/interval_clock_with_compare_unit.sv =====
// Top level of the interval clock with compare: input register, core, result register.
//
// Usage: each input word on i_in carries an action (tick, holding write, director
// function or counter read) and a 16-bit data field. Every accepted word produces
// exactly one result word on o_out with the counter value (reads only, else zero),
// a status bit (set when a director word is rejected) and the latched interrupt.
// An accepted word passes the input register, then the result register, to o_out.
// One word per cycle while o_out is not stalled; the input register feeds the state
// update in the core, which writes the result register in the same cycle.
// Stall: when the receiver holds o_out.ready low, the result register keeps its
// word and the input register fills; i_in.ready drops once both are full and
// rises again in the cycle the receiver takes the result.
// Reset: synchronous, active low; clears the counter, holding value, run and
// interrupt flags, and both register stages become empty.
module interval_clock_with_compare_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    icc_in_if.sink      i_in,
    icc_out_if.source   o_out
);

    logic                       r_s1_valid;
    icc_pkg::t_action           r_s1_action;
    logic [icc_pkg::DATA_W-1:0] r_s1_data;
    logic                       r_out_valid;
    icc_pkg::t_action           r_out_action;
    icc_pkg::t_res              r_out_res;
    logic                       w_s1_adv;
    logic                       w_in_acc;
    icc_pkg::t_cmd              w_cmd;
    icc_pkg::t_res              w_res;

    // Handshake: the input stage moves on whenever the result register is free.
    assign w_s1_adv   = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || w_s1_adv;
    assign w_in_acc   = i_in.valid && i_in.ready;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1_action <= icc_pkg::t_action'(i_in.action);
            r_s1_data   <= i_in.data;
        end
    end

    assign w_cmd.valid  = w_s1_adv;
    assign w_cmd.action = r_s1_action;
    assign w_cmd.data   = r_s1_data;

    icc_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_res   (w_res)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv) begin
            r_out_res    <= w_res;
            r_out_action <= r_s1_action;
        end
    end

    assign o_out.valid             = r_out_valid;
    assign o_out.read_data         = r_out_res.read_data;
    assign o_out.status            = r_out_res.status;
    assign o_out.interrupt_pending = r_out_res.interrupt_pending;

    // Only a counter read returns nonzero read data.
    a_read_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_action != icc_pkg::ACT_READ)) |-> (o_out.read_data == '0))
        else $error("read data nonzero on a non-read word");

    // Only a director word can be rejected.
    a_status_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (o_out.status == icc_pkg::STATUS_REJECTED))
            |-> (r_out_action == icc_pkg::ACT_DIRECT))
        else $error("rejected status on a non-director word");

    // A word held in the input stage is not dropped while the output is stalled.
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !w_s1_adv) |=> (r_s1_valid && $stable(r_s1_data)))
        else $error("input stage lost a stalled word");

endmodule
